[rtl/utf8_sanitizer_top_macros.svh]
// ----------------------------------------------------------------------------
// utf8_sanitizer_top assertion macros
// Shared concurrent assertion forms, all clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZER_TOP_MACROS_SVH
`define UTF8_SANITIZER_TOP_MACROS_SVH

// same-cycle implication
`define UTF8S_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UTF8S_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/utf8s_pkg.sv]
// ----------------------------------------------------------------------------
// utf8s_pkg
// Types, constants and byte classifiers for the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8s_pkg;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned RES_FIFO_AW = 4;

    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] LEAD2_MIN    = 8'hC2;
    localparam logic [7:0] LEAD3_BASE   = 8'hE0;
    localparam logic [7:0] LEAD4_BASE   = 8'hF0;
    localparam logic [7:0] LEAD4_MAX    = 8'hF4;
    localparam logic [7:0] HI_NIBBLE    = 8'hF0;
    localparam logic [7:0] LEAD_SURR    = 8'hED;
    localparam logic [7:0] CONT_MIN     = 8'h80;
    localparam logic [7:0] CONT_MAX     = 8'hBF;
    localparam logic [7:0] E0_CONT_MIN  = 8'hA0;
    localparam logic [7:0] ED_CONT_MAX  = 8'h9F;
    localparam logic [7:0] F0_CONT_MIN  = 8'h90;
    localparam logic [7:0] F4_CONT_MAX  = 8'h8F;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic       text_end;
        logic       run_end;
        logic       has_byte;
        logic [7:0] out_byte;
    } res_t;

    typedef struct packed {
        logic [2:0]                  count;
        res_t [MAX_RESULTS-1:0]      lane;
    } scan_out_t;

    // sequence length opened by a lead byte, 0 if not a lead
    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] len;
        begin
            len = 3'd0;
            if (c >= LEAD2_MIN && c < LEAD3_BASE)
            begin
                len = 3'd2;
            end
            else if ((c & HI_NIBBLE) == LEAD3_BASE)
            begin
                len = 3'd3;
            end
            else if (c >= LEAD4_BASE && c <= LEAD4_MAX)
            begin
                len = 3'd4;
            end
            return len;
        end
    endfunction

    // continuation byte check; the second byte narrows for some leads
    function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        begin
            lo = CONT_MIN;
            hi = CONT_MAX;
            if (pos == 2'd1)
            begin
                if (lead == LEAD3_BASE)
                begin
                    lo = E0_CONT_MIN;
                end
                else if (lead == LEAD_SURR)
                begin
                    hi = ED_CONT_MAX;
                end
                else if (lead == LEAD4_BASE)
                begin
                    lo = F0_CONT_MIN;
                end
                else if (lead == LEAD4_MAX)
                begin
                    hi = F4_CONT_MAX;
                end
            end
            return (b >= lo) && (b <= hi);
        end
    endfunction

endpackage

`default_nettype wire

[rtl/utf8_sanitizer_top.sv]
// ----------------------------------------------------------------------------
// utf8_sanitizer_top
// Byte-stream filter that passes only well-formed UTF-8.
//
// Channel  Dir  tdata              tuser                     tlast
// s_axis   in   [7:0] in_byte      -                         text_last
// m_axis   out  [7:0] out_byte     [0] has_byte [1] run_end  text_end
//
// A byte is registered on acceptance and scanned in the next cycle; its
// results (0 to 4) are written to a result FIFO at the end of that cycle.
// s_axis takes one byte per cycle while the FIFO has room for two bytes'
// worth of results; m_axis drains one result per cycle unless stalled.
// Reset clears the open sequence and empties the FIFO; nothing is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_sanitizer_top
    import utf8s_pkg::*;
#(
    parameter int unsigned FIFO_AW = RES_FIFO_AW
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]      m_axis_tuser,   // [0] has_byte, [1] run_end
    output logic            m_axis_tlast
);

    localparam int unsigned Depth = 1 << FIFO_AW;

    logic              item_valid_reg;
    item_t             item_reg;
    scan_out_t         scan_out;

    res_t              fifo_reg [Depth];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    logic              in_fire;
    logic              out_fire;
    res_t              head;

    // room for the item in the scan stage plus the one being accepted
    assign s_axis_tready = count_reg <= (FIFO_AW+1)'(Depth - 2 * MAX_RESULTS);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = count_reg != '0;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    assign head          = fifo_reg[rd_ptr_reg];
    assign m_axis_tdata  = head.out_byte;
    assign m_axis_tuser  = {head.run_end, head.has_byte};
    assign m_axis_tlast  = head.text_end;

    utf8s_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .scan_out   (scan_out)
    );

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(scan_out.count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(out_fire);
        count_next  = count_reg + (FIFO_AW+1)'(scan_out.count)
                      - (FIFO_AW+1)'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= in_fire;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.data <= s_axis_tdata;
            item_reg.last <= s_axis_tlast;
        end
        // push this cycle's results in order behind the write pointer
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (3'(i) < scan_out.count)
            begin
                fifo_reg[wr_ptr_reg + FIFO_AW'(i)] <= scan_out.lane[i];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/utf8s_scan.sv]
// ----------------------------------------------------------------------------
// utf8s_scan
// Holds the open sequence and classifies one registered byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8s_scan
    import utf8s_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    input  wire item_t     item,
    output scan_out_t      scan_out
);

    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [2:0] seq_len_reg;
    logic [2:0] seq_len_next;

    logic       cont_good;
    logic       seq_mode;
    logic       seq_done;
    logic       seq_emit;
    logic [2:0] fresh_len;
    logic [2:0] cnt;
    logic       bare;

    always_comb
    begin
        cont_good = cont_ok(held_reg[0], held_count_reg, item.data);
        seq_mode  = (held_count_reg != 2'd0) && cont_good;
        seq_done  = ({1'b0, held_count_reg} + 3'd1) == seq_len_reg;
        fresh_len = lead_len(item.data);
        seq_emit  = 1'b0;
        cnt       = 3'd0;
        bare      = 1'b0;

        held_next       = held_reg;
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;

        if (item_valid)
        begin
            held_next[0]    = 8'h00;
            held_next[1]    = 8'h00;
            held_next[2]    = 8'h00;
            held_count_next = 2'd0;
            seq_len_next    = 3'd0;
            if (seq_mode)
            begin
                if (seq_done)
                begin
                    seq_emit = 1'b1;
                    cnt      = seq_len_reg;
                end
                else if (!item.last)
                begin
                    // extend the open sequence
                    held_next                 = held_reg;
                    held_next[held_count_reg] = item.data;
                    held_count_next           = held_count_reg + 2'd1;
                    seq_len_next              = seq_len_reg;
                end
                // truncated at end of text: lead dropped, continuations drop too
            end
            else
            begin
                // lead dropped (if any); held continuations drop on rescan
                if (item.data < ASCII_LIMIT)
                begin
                    cnt = 3'd1;
                end
                else if (fresh_len != 3'd0 && !item.last)
                begin
                    held_next[0]    = item.data;
                    held_count_next = 2'd1;
                    seq_len_next    = fresh_len;
                end
            end
            if (cnt == 3'd0 && item.last)
            begin
                bare = 1'b1;
                cnt  = 3'd1;
            end
        end

        scan_out.count = cnt;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            scan_out.lane[i].out_byte = item.data;
            scan_out.lane[i].has_byte = !bare;
            scan_out.lane[i].run_end  = (3'(i) + 3'd1) == cnt;
            scan_out.lane[i].text_end = ((3'(i) + 3'd1) == cnt) && item.last;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (seq_emit && (2'(i) < held_count_reg))
            begin
                scan_out.lane[i].out_byte = held_reg[i];
            end
        end
        if (bare)
        begin
            scan_out.lane[0].out_byte = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg[0]    <= 8'h00;
            held_reg[1]    <= 8'h00;
            held_reg[2]    <= 8'h00;
            held_count_reg <= 2'd0;
            seq_len_reg    <= 3'd0;
        end
        else
        begin
            held_reg       <= held_next;
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
        end
    end

endmodule

`default_nettype wire

[rtl/utf8s_checker.sv]
// ----------------------------------------------------------------------------
// utf8s_checker
// Port-level checks on the sanitizer output stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_sanitizer_top_macros.svh"

module utf8s_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic       s_axis_tlast,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    logic in_seen;
    assign in_seen = s_axis_tvalid | s_axis_tready | s_axis_tlast | (|s_axis_tdata);

    // a stalled item holds
    `UTF8S_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output item changed while stalled")

    // a bare end marker is zero, closes its run and the text
    `UTF8S_ASSERT_NOW(a_bare_marker, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'h00 && m_axis_tuser[1] && m_axis_tlast, "malformed bare end marker")

    // end of text is always the last item of its run
    `UTF8S_ASSERT_NOW(a_text_end_run, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1], "text end without run end")

    // never-valid bytes must not pass
    `UTF8S_ASSERT_NOW(a_no_bad_byte, m_axis_tvalid && m_axis_tuser[0] && in_seen | m_axis_tvalid && m_axis_tuser[0], m_axis_tdata != 8'hC0 && m_axis_tdata != 8'hC1 && m_axis_tdata < 8'hF5, "invalid byte on output")

endmodule

bind utf8_sanitizer_top utf8s_checker u_checker (.*);

`default_nettype wire
